// ----- rtl/core/rv32sde_pkg.sv -----
// Shared types, opcode constants and sizes for the RV32 subset decode/execute block.
package rv32sde_pkg;

  // Data memory size in bytes; a power of two, stored as four byte lanes.
  localparam int MemBytes = 4096;
  localparam int Lanes    = 4;
  localparam int LaneW    = $clog2(Lanes);
  localparam int MemRows  = MemBytes / Lanes;
  localparam int RowW     = $clog2(MemRows);
  localparam int AddrW    = $clog2(MemBytes);

  localparam int NumRegs  = 32;
  localparam int RegW     = $clog2(NumRegs);
  localparam int XLen     = 32;

  // Depth of the queue between decode and execute.
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // Reset value of the start address register, which is also the pc after reset.
  localparam logic [XLen-1:0] PcRst = 32'h0000_0000;

  localparam logic [6:0] OpcOpImm = 7'b0010011;
  localparam logic [6:0] OpcJalr  = 7'b1100111;
  localparam logic [6:0] OpcOp    = 7'b0110011;
  localparam logic [6:0] OpcLui   = 7'b0110111;
  localparam logic [6:0] OpcLoad  = 7'b0000011;
  localparam logic [6:0] OpcStore = 7'b0100011;

  localparam logic [2:0] F3Zero   = 3'b000;
  localparam logic [2:0] F3Word   = 3'b010;
  localparam logic [2:0] F3ByteU  = 3'b100;
  localparam logic [6:0] F7Zero   = 7'b0000000;

  localparam logic [XLen-1:0] UpperMask = 32'hFFFF_F000;

  typedef enum logic [3:0] {
    KindAddi = 4'd0,
    KindJalr = 4'd1,
    KindAdd  = 4'd2,
    KindLui  = 4'd3,
    KindLw   = 4'd4,
    KindLbu  = 4'd5,
    KindSb   = 4'd6,
    KindSw   = 4'd7,
    KindBad  = 4'd8
  } kind_e;

  // One decoded instruction as it travels from decode to execute.
  typedef struct packed {
    kind_e            kind;
    logic             wr;    // writes a register other than x0
    logic [RegW-1:0]  rd;    // zero when wr is low
    logic [RegW-1:0]  rs1;
    logic [RegW-1:0]  rs2;
    logic [XLen-1:0]  imm;
  } op_t;

endpackage

// ----- rtl/core/rv32sde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rv32sde_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/rv32sde_decode.sv -----
// Front end: classifies an instruction word and extracts its register fields and immediate.
module rv32sde_decode (
  input  logic [31:0]        instr_i,
  output rv32sde_pkg::op_t   op_o
);
  import rv32sde_pkg::*;

  logic [6:0]      opcode;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLen-1:0] imm_i;
  logic [XLen-1:0] imm_s;
  kind_e           kind;
  logic            writes;

  assign opcode = instr_i[6:0];
  assign f3     = instr_i[14:12];
  assign f7     = instr_i[31:25];
  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};

  always_comb begin
    kind = KindBad;
    case (opcode)
      OpcOpImm: begin
        if (f3 == F3Zero) kind = KindAddi;
      end
      OpcJalr: begin
        if (f3 == F3Zero) kind = KindJalr;
      end
      OpcOp: begin
        if (f3 == F3Zero && f7 == F7Zero) kind = KindAdd;
      end
      OpcLui: begin
        kind = KindLui;
      end
      OpcLoad: begin
        if (f3 == F3Word) kind = KindLw;
        else if (f3 == F3ByteU) kind = KindLbu;
      end
      OpcStore: begin
        if (f3 == F3Zero) kind = KindSb;
        else if (f3 == F3Word) kind = KindSw;
      end
      default: kind = KindBad;
    endcase
  end

  assign writes = (kind inside {KindAddi, KindJalr, KindAdd, KindLui, KindLw, KindLbu}) &&
                  (instr_i[11:7] != '0);

  always_comb begin
    op_o.kind = kind;
    op_o.wr   = writes;
    op_o.rd   = writes ? instr_i[11:7] : '0;
    op_o.rs1  = instr_i[19:15];
    op_o.rs2  = instr_i[24:20];
    case (kind)
      KindLui:        op_o.imm = instr_i & UpperMask;
      KindSb, KindSw: op_o.imm = imm_s;
      default:        op_o.imm = imm_i;
    endcase
  end

endmodule

// ----- rtl/core/rv32sde_queue.sv -----
// Short queue of decoded instructions between the decode and execute sides.
module rv32sde_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rv32sde_pkg::op_t  op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rv32sde_pkg::op_t  op_o
);
  import rv32sde_pkg::*;

  op_t              entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ----- rtl/core/rv32sde_execute.sv -----
// Back end: register read, execute with memory access, and result/writeback stage.
module rv32sde_execute (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_valid_i,
  input  rv32sde_pkg::op_t       op_i,
  output logic                   pop_o,
  output logic                   clr_busy_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             op_kind_o,
  output logic [31:0]            next_pc_o,
  output logic                   reg_write_o,
  output logic [4:0]             dest_index_o,
  output logic [31:0]            dest_value_o
);
  import rv32sde_pkg::*;

  logic adv;

  // Memory clearing pass after reset, one row of all lanes per cycle.
  logic            clr_busy_q;
  logic [RowW-1:0] clr_row_q;

  // Register read results captured with the instruction entering execute.
  logic            x_valid_q;
  op_t             x_op_q;
  logic [XLen-1:0] rf_rd1, rf_rd2;
  logic            rv1_q, rv2_q;
  logic [NumRegs-1:0] rf_valid_q;

  // Last register write, for the read that happened at the same edge.
  logic            wb_valid_q;
  logic [RegW-1:0] wb_idx_q;
  logic [XLen-1:0] wb_data_q;

  logic [XLen-1:0] pc_q;

  // Result stage, which also drives the outputs.
  logic             m_valid_q;
  kind_e            m_kind_q;
  logic [XLen-1:0]  m_npc_q;
  logic             m_we_q;
  logic [RegW-1:0]  m_rd_q;
  logic [XLen-1:0]  m_val_q;
  logic [LaneW-1:0] m_off_q;
  logic [XLen-1:0]  m_result;

  logic             rf_we;
  logic [XLen-1:0]  rs1_val, rs2_val;
  logic [XLen-1:0]  op_b, sum, pc_plus4, x_val, x_npc;
  logic [LaneW-1:0] x_off;
  logic [RowW-1:0]  x_row;
  logic             x_load;

  logic [7:0]       lane_rdata [Lanes];
  logic [7:0]       lane_wdata [Lanes];
  logic [RowW-1:0]  lane_row   [Lanes];
  logic [RowW-1:0]  lane_waddr [Lanes];
  logic [Lanes-1:0] lane_we;
  logic [XLen-1:0]  mem_word;
  logic [2*XLen-1:0] ld_rot;
  logic [2*XLen-1:0] st_rot;
  logic [XLen-1:0]  ld_word;

  assign adv   = !m_valid_q || !out_stall_i;
  assign pop_o = adv && op_valid_i && !clr_busy_q;
  assign rf_we = adv && m_valid_q && m_we_q;
  assign clr_busy_o = clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + 1'b1;
      if (clr_row_q == RowW'(MemRows - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Two copies of the register file give the two read ports.
  rv32sde_ram #(.Width(XLen), .Depth(NumRegs)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (m_rd_q),
    .wdata_i (m_result),
    .re_i    (pop_o),
    .raddr_i (op_i.rs1),
    .rdata_o (rf_rd1)
  );

  rv32sde_ram #(.Width(XLen), .Depth(NumRegs)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (m_rd_q),
    .wdata_i (m_result),
    .re_i    (pop_o),
    .raddr_i (op_i.rs2),
    .rdata_o (rf_rd2)
  );

  // A register never written reads as zero; x0 is never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      wb_valid_q <= 1'b0;
      x_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      pc_q       <= PcRst;
    end else begin
      if (rf_we) begin
        rf_valid_q[m_rd_q] <= 1'b1;
        wb_valid_q         <= 1'b1;
      end
      if (adv) begin
        x_valid_q <= pop_o;
        m_valid_q <= x_valid_q;
        if (x_valid_q) begin
          pc_q <= x_npc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      wb_idx_q  <= m_rd_q;
      wb_data_q <= m_result;
    end
    if (pop_o) begin
      x_op_q <= op_i;
      rv1_q  <= rf_valid_q[op_i.rs1];
      rv2_q  <= rf_valid_q[op_i.rs2];
    end
    if (adv) begin
      m_kind_q <= x_op_q.kind;
      m_npc_q  <= x_npc;
      m_we_q   <= x_op_q.wr;
      m_rd_q   <= x_op_q.rd;
      m_val_q  <= x_val;
      m_off_q  <= x_off;
    end
  end

  // Operand bypass: the result stage is newest, then the last completed write.
  always_comb begin
    rs1_val = rv1_q ? rf_rd1 : '0;
    rs2_val = rv2_q ? rf_rd2 : '0;
    if (wb_valid_q && wb_idx_q == x_op_q.rs1) rs1_val = wb_data_q;
    if (wb_valid_q && wb_idx_q == x_op_q.rs2) rs2_val = wb_data_q;
    if (m_valid_q && m_we_q && m_rd_q == x_op_q.rs1) rs1_val = m_result;
    if (m_valid_q && m_we_q && m_rd_q == x_op_q.rs2) rs2_val = m_result;
  end

  assign op_b     = (x_op_q.kind == KindAdd) ? rs2_val : x_op_q.imm;
  assign sum      = rs1_val + op_b;
  assign pc_plus4 = pc_q + 32'd4;
  assign x_load   = (x_op_q.kind == KindLw) || (x_op_q.kind == KindLbu);
  assign x_off    = sum[LaneW-1:0];
  assign x_row    = sum[AddrW-1:LaneW];

  always_comb begin
    case (x_op_q.kind)
      KindAddi, KindAdd: x_val = sum;
      KindJalr:          x_val = pc_plus4;
      KindLui:           x_val = x_op_q.imm;
      default:           x_val = '0;
    endcase
    if (!x_op_q.wr) x_val = '0;
    case (x_op_q.kind)
      KindBad:  x_npc = pc_q;
      KindJalr: x_npc = {sum[XLen-1:1], 1'b0};
      default:  x_npc = pc_plus4;
    endcase
  end

  // Byte i of an access sits in lane (off + i) mod 4; lanes below off wrap to the next row.
  assign st_rot = {rs2_val, rs2_val} << {x_off, 3'b000};

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      lane_row[k]   = x_row + RowW'(LaneW'(k) < x_off);
      lane_wdata[k] = clr_busy_q ? 8'h00 : st_rot[XLen + 8*k +: 8];
      lane_waddr[k] = clr_busy_q ? clr_row_q : lane_row[k];
      lane_we[k]    = clr_busy_q ||
                      (adv && x_valid_q &&
                       ((x_op_q.kind == KindSw) ||
                        (x_op_q.kind == KindSb && LaneW'(k) == x_off)));
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    rv32sde_ram #(.Width(8), .Depth(MemRows)) u_mem (
      .clk_i   (clk_i),
      .we_i    (lane_we[k]),
      .waddr_i (lane_waddr[k]),
      .wdata_i (lane_wdata[k]),
      .re_i    (adv && x_valid_q && x_load),
      .raddr_i (lane_row[k]),
      .rdata_o (lane_rdata[k])
    );
    assign mem_word[8*k +: 8] = lane_rdata[k];
  end

  assign ld_rot  = {mem_word, mem_word} >> {m_off_q, 3'b000};
  assign ld_word = ld_rot[XLen-1:0];

  always_comb begin
    if (!m_we_q) begin
      m_result = '0;
    end else begin
      case (m_kind_q)
        KindLw:  m_result = ld_word;
        KindLbu: m_result = {24'h000000, ld_word[7:0]};
        default: m_result = m_val_q;
      endcase
    end
  end

  assign out_valid_o  = m_valid_q;
  assign op_kind_o    = m_kind_q;
  assign next_pc_o    = m_npc_q;
  assign reg_write_o  = m_we_q;
  assign dest_index_o = m_rd_q;
  assign dest_value_o = m_result;

endmodule

// ----- rtl/core/rv32_subset_decode_execute.sv -----
// Top level of the RV32 subset decode/execute block: decode, queue and execute back end.
// A result passes the queue, the execute stage and the result stage before it is valid.
// Throughput: one instruction per cycle while results are not stalled and memory is not being cleared,
// with no bubble after a load thanks to the bypass. A stalled result holds execute; the two-entry queue
// still takes transfers until it is full. After reset the data memory is cleared one row at a time, with input stalled.
// Reset sets the pc to the start address register's reset value, zero, and all registers read zero.
module rv32_subset_decode_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  op_kind_o,
  output logic [31:0] next_pc_o,
  output logic        reg_write_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o
);
  import rv32sde_pkg::*;

  op_t  dec_op;
  op_t  q_op;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic clr_busy;
  logic push;

  // The start address only matters at reset, where it returns to its reset value,
  // so a written value never reaches the pc and cfg_we_i/cfg_wdata_i need no storage.

  assign in_stall_o = q_full || clr_busy;
  assign push       = in_valid_i && !in_stall_o;

  rv32sde_decode u_decode (
    .instr_i (instr_i),
    .op_o    (dec_op)
  );

  rv32sde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (dec_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  rv32sde_execute u_execute (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_i         (q_op),
    .pop_o        (q_pop),
    .clr_busy_o   (clr_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .op_kind_o    (op_kind_o),
    .next_pc_o    (next_pc_o),
    .reg_write_o  (reg_write_o),
    .dest_index_o (dest_index_o),
    .dest_value_o (dest_value_o)
  );

  a_write_not_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_write_o |-> dest_index_o != 5'd0)
    else $error("register write reported for x0");

  a_bad_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_kind_o == KindBad |-> !reg_write_o && dest_value_o == 32'd0)
    else $error("unsupported instruction reported a write");

  a_jalr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_kind_o == KindJalr |-> !next_pc_o[0])
    else $error("jalr target has bit 0 set");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !out_valid_o && !q_pop)
    else $error("instruction executed during memory clear");

endmodule

// ----- test/retire_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts every retired instruction and compares it with the block's results.
module retire_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] instr_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  op_kind_i,
  input  logic [31:0] next_pc_i,
  input  logic        reg_write_i,
  input  logic [4:0]  dest_index_i,
  input  logic [31:0] dest_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  import rv32sde_pkg::*;

  typedef struct packed {
    kind_e            kind;
    logic [XLen-1:0]  next_pc;
    logic             wr;
    logic [RegW-1:0]  rd;
    logic [XLen-1:0]  value;
  } retire_t;

  logic [XLen-1:0] gpr [NumRegs];
  logic [7:0]      dmem [MemBytes];
  logic [XLen-1:0] pc;
  logic [XLen-1:0] start_addr;
  retire_t         predicted_retires [$];
  int              fails = 0;

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", fname, exp_v, act_v);
      fails++;
    end
  endtask

  // Executes one instruction on the shadow state and returns what the block should report.
  task automatic execute_instr(input logic [31:0] w, output retire_t r);
    logic [6:0]       opc;
    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [RegW-1:0]  rd;
    logic [XLen-1:0]  a;
    logic [XLen-1:0]  b;
    logic [XLen-1:0]  imm_i;
    logic [XLen-1:0]  imm_s;
    logic [XLen-1:0]  ea;
    logic [XLen-1:0]  val;
    logic [XLen-1:0]  npc;
    logic [AddrW-1:0] idx;
    kind_e            kind;
    logic             wr;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    f7    = w[31:25];
    a     = gpr[w[19:15]];
    b     = gpr[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    kind  = KindBad;
    wr    = 1'b0;
    val   = '0;
    if (opc == OpcOpImm && f3 == F3Zero) begin
      kind = KindAddi;
      wr   = 1'b1;
      val  = a + imm_i;
    end else if (opc == OpcJalr && f3 == F3Zero) begin
      kind = KindJalr;
      wr   = 1'b1;
      val  = pc + 32'd4;
    end else if (opc == OpcOp && f3 == F3Zero && f7 == F7Zero) begin
      kind = KindAdd;
      wr   = 1'b1;
      val  = a + b;
    end else if (opc == OpcLui) begin
      kind = KindLui;
      wr   = 1'b1;
      val  = w & UpperMask;
    end else if (opc == OpcLoad && f3 == F3Word) begin
      kind = KindLw;
      wr   = 1'b1;
      ea   = a + imm_i;
      for (int i = 0; i < 4; i++) begin
        idx = ea[AddrW-1:0] + AddrW'(i);
        val[8*i +: 8] = dmem[idx];
      end
    end else if (opc == OpcLoad && f3 == F3ByteU) begin
      kind = KindLbu;
      wr   = 1'b1;
      ea   = a + imm_i;
      val  = {24'd0, dmem[ea[AddrW-1:0]]};
    end else if (opc == OpcStore && f3 == F3Zero) begin
      kind = KindSb;
      ea   = a + imm_s;
      dmem[ea[AddrW-1:0]] = b[7:0];
    end else if (opc == OpcStore && f3 == F3Word) begin
      kind = KindSw;
      ea   = a + imm_s;
      for (int i = 0; i < 4; i++) begin
        idx = ea[AddrW-1:0] + AddrW'(i);
        dmem[idx] = b[8*i +: 8];
      end
    end

    if (kind == KindJalr) begin
      npc = (a + imm_i) & ~32'd1;
    end else if (kind == KindBad) begin
      npc = pc;
    end else begin
      npc = pc + 32'd4;
    end

    // A write to x0 is dropped and reported as no write at all.
    if (!wr || rd == '0) begin
      wr  = 1'b0;
      rd  = '0;
      val = '0;
    end else begin
      gpr[rd] = val;
    end
    pc = npc;

    r.kind    = kind;
    r.next_pc = npc;
    r.wr      = wr;
    r.rd      = rd;
    r.value   = val;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t r;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
      for (int i = 0; i < MemBytes; i++) dmem[i] = '0;
      start_addr = PcRst;
      pc = start_addr;
      predicted_retires.delete();
    end else begin
      // The start address only matters at reset, so a write is merely recorded.
      if (cfg_we_i) begin
        start_addr = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (predicted_retires.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          fails++;
        end else begin
          r = predicted_retires.pop_front();
          check_field("op_kind", 32'(r.kind), 32'(op_kind_i));
          check_field("next_pc", r.next_pc, next_pc_i);
          check_field("reg_write", 32'(r.wr), 32'(reg_write_i));
          check_field("dest_index", 32'(r.rd), 32'(dest_index_i));
          check_field("dest_value", r.value, dest_value_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        execute_instr(instr_i, r);
        predicted_retires.push_back(r);
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_retires.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives instruction and start address traffic and reports the verdict.
module tb;
  import rv32sde_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int RandPerPhase = 234;

  // Encodings outside the subset, used for rejection cases.
  localparam logic [6:0] OpcJal = 7'b1101111;
  localparam logic [6:0] F7Sub  = 7'b0100000;
  localparam logic [2:0] F3One  = 3'b001;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [31:0] instr     = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  op_kind;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          send_burst  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rv32_subset_decode_execute uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .instr_i      (instr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .op_kind_o    (op_kind),
    .next_pc_o    (next_pc),
    .reg_write_o  (reg_write),
    .dest_index_o (dest_index),
    .dest_value_o (dest_value)
  );

  retire_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .instr_i      (instr),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .op_kind_i    (op_kind),
    .next_pc_i    (next_pc),
    .reg_write_i  (reg_write),
    .dest_index_i (dest_index),
    .dest_value_i (dest_value),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpcStore};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [4:0] rs2);
    return {f7, rs2, rs1, F3Zero, rd, OpcOp};
  endfunction

  // Mostly well-formed instructions; memory accesses cluster in a small window so that
  // loads see earlier stores. The rest is near-miss encodings and raw noise.
  function automatic logic [31:0] random_instr();
    int          pick;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  mem_rs1;
    logic [11:0] imm;
    logic [11:0] mem_imm;
    logic [31:0] w;
    logic [6:0]  opcs [6];
    pick    = $urandom_range(0, 99);
    rd      = 5'($urandom);
    rs1     = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    rs2     = 5'($urandom);
    imm     = 12'($urandom);
    mem_rs1 = ($urandom_range(0, 1) == 1) ? 5'd0 : rs1;
    mem_imm = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 71) - 8) : imm;
    opcs    = '{OpcOpImm, OpcJalr, OpcOp, OpcLui, OpcLoad, OpcStore};
    w       = $urandom;
    if (pick < 18) begin
      w = enc_i(OpcOpImm, F3Zero, rd, rs1, imm);
    end else if (pick < 25) begin
      w = enc_i(OpcJalr, F3Zero, rd, rs1, imm);
    end else if (pick < 37) begin
      w = enc_r(F7Zero, rd, rs1, rs2);
    end else if (pick < 45) begin
      w = {20'($urandom), rd, OpcLui};
    end else if (pick < 57) begin
      w = enc_i(OpcLoad, F3Word, rd, mem_rs1, mem_imm);
    end else if (pick < 67) begin
      w = enc_i(OpcLoad, F3ByteU, rd, mem_rs1, mem_imm);
    end else if (pick < 77) begin
      w = enc_s(F3Zero, mem_rs1, rs2, mem_imm);
    end else if (pick < 89) begin
      w = enc_s(F3Word, mem_rs1, rs2, mem_imm);
    end else if (pick < 95) begin
      w[6:0] = opcs[$urandom_range(0, 5)];
    end
    return w;
  endfunction

  task automatic send_instr(input logic [31:0] w);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      send_burst = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    instr    <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every result has come back, then writes the start address.
  task automatic drain_and_set_start(input logic [31:0] v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: a random stall before each transfer, with occasional runs without stalls.
  initial begin
    int hold;
    int burst;
    burst = 0;
    forever begin
      if (burst > 0) begin
        hold = 0;
        burst--;
      end else if ($urandom_range(0, 15) == 0) begin
        hold = 0;
        burst = $urandom_range(10, 40);
      end else begin
        hold = $urandom_range(0, 13);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] start_values [3];
    start_values = '{32'h0000_0000, $urandom, 32'h8000_0000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    drain_and_set_start(32'hFFFF_FFFF);
    send_instr({20'hFFFFF, 5'd1, OpcLui});                      // x1 = 0xFFFFF000
    send_instr(enc_i(OpcOpImm, F3Zero, 5'd2, 5'd0, 12'h7FF));   // largest immediate
    send_instr(enc_i(OpcOpImm, F3Zero, 5'd3, 5'd0, 12'h800));   // most negative immediate
    send_instr(enc_r(F7Zero, 5'd4, 5'd1, 5'd2));
    send_instr(enc_r(F7Zero, 5'd9, 5'd1, 5'd1));                // sum wraps
    send_instr(enc_s(F3Word, 5'd0, 5'd4, 12'hFFE));             // word wraps past the top
    send_instr(enc_i(OpcLoad, F3Word, 5'd5, 5'd0, 12'hFFE));
    send_instr(enc_i(OpcLoad, F3ByteU, 5'd6, 5'd0, 12'h000));
    send_instr(enc_s(F3Zero, 5'd0, 5'd3, 12'd3));
    send_instr(enc_i(OpcLoad, F3Word, 5'd7, 5'd0, 12'd1));      // misaligned word
    send_instr(enc_s(F3Word, 5'd4, 5'd1, 12'd5));
    send_instr(enc_i(OpcLoad, F3ByteU, 5'd10, 5'd4, 12'h7FF));
    send_instr(enc_i(OpcOpImm, F3Zero, 5'd0, 5'd2, 12'd5));     // write to x0 dropped
    send_instr({20'hABCDE, 5'd0, OpcLui});
    send_instr(enc_i(OpcOpImm, F3Zero, 5'd8, 5'd0, 12'h101));
    send_instr(enc_i(OpcJalr, F3Zero, 5'd8, 5'd8, 12'd6));      // rd equals rs1, odd target
    send_instr(enc_i(OpcJalr, F3Zero, 5'd0, 5'd1, 12'hFFF));
    send_instr(enc_r(F7Sub, 5'd11, 5'd1, 5'd2));
    send_instr(enc_i(OpcOpImm, F3One, 5'd12, 5'd1, 12'd1));
    send_instr(enc_i(OpcLoad, F3Zero, 5'd13, 5'd0, 12'd0));
    send_instr(enc_s(F3One, 5'd0, 5'd1, 12'd8));
    send_instr({25'h1FFFFFF, OpcJal});
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_i(OpcOpImm, F3Zero, 5'd11, 5'd1, 12'hFFF));
    in_valid <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      drain_and_set_start(start_values[p]);
      for (int n = 0; n < RandPerPhase; n++) begin
        send_instr(random_instr());
      end
      in_valid <= 1'b0;
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rv32sde_pkg.sv
rtl/core/rv32sde_ram.sv
rtl/core/rv32sde_decode.sv
rtl/core/rv32sde_queue.sv
rtl/core/rv32sde_execute.sv
rtl/core/rv32_subset_decode_execute.sv
test/retire_checker.sv
test/tb.sv
